// ===== design/csc_pkg.sv =====
// csc_pkg: shared types and constants of the colour sequence crossfade block
// no dependencies
package csc_pkg;

	localparam int CH_W  = 8;
	localparam int RGB_W = 3 * CH_W;
	localparam int CFG_W = 16;

	localparam logic [1:0] CFG_SUSTAIN    = 2'd0;
	localparam logic [1:0] CFG_TRANSITION = 2'd1;
	localparam logic [1:0] CFG_COUNT      = 2'd2;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// item travelling through the divide pipelines
	typedef struct packed {
		logic             wr;
		logic [3:0]       idx;
		logic [RGB_W-1:0] rgb;
	} item_t;

endpackage

// ===== design/color_sequence_crossfade.sv =====
// color_sequence_crossfade: rgb colour sequence with linear crossfade
// one transfer per cycle while out_ready allows it; a tick passes the modulo, segment, table,
// product, numerator and blend stages in that order, each divider giving one quotient bit per stage
// write items ride the modulo and segment dividers and update the table ram in order
// reset (arst_n, async, low) empties all stages and loads the register defaults
// table contents are undefined until written; uses csc_pkg, csc_divpipe, csc_ram
module color_sequence_crossfade #(
	parameter int MAX_COLORS = 16,
	parameter int TICK_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] tick_count,
	input  logic [3:0]  entry_index,
	input  logic [7:0]  entry_red,
	input  logic [7:0]  entry_green,
	input  logic [7:0]  entry_blue,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [3:0]  segment_index,
	output logic        fading
);

	localparam int IW   = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;   // table address
	localparam int CNTW = $clog2(MAX_COLORS + 1);                      // colour count
	localparam int PW   = csc_pkg::CFG_W + 1;                          // period
	localparam int CW   = PW + CNTW;                                   // cycle length
	localparam int NW1  = (TICK_BITS > CW) ? TICK_BITS : CW;
	localparam int BW   = csc_pkg::RGB_W;                              // blend numerator
	localparam int CH   = csc_pkg::CH_W;
	localparam int S3W  = IW + 1 + csc_pkg::RGB_W;

	// configuration registers
	logic [15:0] sustain_q;
	logic [15:0] transition_q;
	logic [4:0]  count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sustain_q    <= '0;
			transition_q <= '0;
			count_q      <= 5'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				csc_pkg::CFG_SUSTAIN:    sustain_q    <= cfg_data;
				csc_pkg::CFG_TRANSITION: transition_q <= cfg_data;
				csc_pkg::CFG_COUNT:      count_q      <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// derived values; the user must keep them stable while items are in flight, the block does not enforce it
	logic [CNTW-1:0] cnt_eff;
	logic [PW-1:0]   period;
	logic [CW-1:0]   cycle_len;

	always_comb begin
		if (count_q == 5'd0) begin
			cnt_eff = CNTW'(1);
		end else if (32'(count_q) > MAX_COLORS) begin
			cnt_eff = CNTW'(MAX_COLORS);
		end else begin
			cnt_eff = CNTW'(count_q);
		end
	end

	assign period    = PW'(sustain_q) + PW'(transition_q);
	assign cycle_len = CW'(period) * CW'(cnt_eff);

	// modulo by the cycle length
	csc_pkg::item_t  item_in, item_m, item_d;
	logic [NW1-1:0]  num1 [1];
	logic [TICK_BITS-1:0] quo1 [1];
	logic [NW1-1:0]  rem1 [1];
	logic            v_m, r_m;

	assign item_in.wr  = (opcode == csc_pkg::OP_WRITE);
	assign item_in.idx = entry_index;
	assign item_in.rgb = {entry_red, entry_green, entry_blue};
	assign num1[0]     = NW1'(TICK_BITS'(tick_count));

	csc_divpipe #(
		.NW(NW1), .QW(TICK_BITS), .LANES(1), .SW($bits(csc_pkg::item_t))
	) u_mod (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_num(num1), .in_den(NW1'(cycle_len)), .in_side(item_in),
		.out_valid(v_m), .out_ready(r_m),
		.out_quo(quo1), .out_rem(rem1), .out_side(item_m)
	);

	// segment and offset within segment
	logic [CW-1:0] num2 [1];
	logic [IW-1:0] quo2 [1];
	logic [CW-1:0] rem2 [1];
	logic          v_d, r_d;

	assign num2[0] = CW'(rem1[0]);

	csc_divpipe #(
		.NW(CW), .QW(IW), .LANES(1), .SW($bits(csc_pkg::item_t))
	) u_seg (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_m), .in_ready(r_m),
		.in_num(num2), .in_den(CW'(period)), .in_side(item_m),
		.out_valid(v_d), .out_ready(r_d),
		.out_quo(quo2), .out_rem(rem2), .out_side(item_d)
	);

	// stage 1: table access; writes commit here so later ticks see them
	logic          v_s1, v_s2, v_s3;
	logic          rdy1, rdy2, rdy3, div3_ready;
	logic          take;
	logic          tbl_we;
	logic [IW-1:0] seg, nxt;
	logic          fade;
	logic [15:0]   into;
	logic [IW-1:0] seg_s1;
	logic          fade_s1;
	logic [15:0]   into_s1, left_s1;
	logic [csc_pkg::RGB_W-1:0] cur_rd, nxt_rd;

	assign rdy3 = !v_s3 || div3_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign r_d  = rdy1;
	assign take = v_d && rdy1;

	assign tbl_we = take && item_d.wr && (32'(item_d.idx) < MAX_COLORS);

	always_comb begin
		// zero period shows entry 0 steadily
		seg  = (period == '0) ? '0 : quo2[0];
		fade = (transition_q != '0) && (period != '0) && (rem2[0] > CW'(sustain_q));
		into = 16'(rem2[0] - CW'(sustain_q));
		// next colour wraps after the last one in use
		if (32'(seg) + 1 >= 32'(cnt_eff)) begin
			nxt = '0;
		end else begin
			nxt = IW'(32'(seg) + 1);
		end
	end

	csc_ram #(.WIDTH(csc_pkg::RGB_W), .DEPTH(MAX_COLORS)) u_tbl_cur (
		.clk(clk), .we(tbl_we), .waddr(IW'(item_d.idx)), .wdata(item_d.rgb),
		.re(take && !item_d.wr), .raddr(seg), .rdata(cur_rd)
	);

	csc_ram #(.WIDTH(csc_pkg::RGB_W), .DEPTH(MAX_COLORS)) u_tbl_nxt (
		.clk(clk), .we(tbl_we), .waddr(IW'(item_d.idx)), .wdata(item_d.rgb),
		.re(take && !item_d.wr), .raddr(nxt), .rdata(nxt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= v_d && !item_d.wr;   // write items end here
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			seg_s1  <= seg;
			fade_s1 <= fade;
			into_s1 <= into;
			left_s1 <= transition_q - into;
		end
	end

	// stage 2: channel products
	logic [CH+15:0] pc_s2 [3];
	logic [CH+15:0] pn_s2 [3];
	logic [IW-1:0]  seg_s2;
	logic           fade_s2;
	logic [csc_pkg::RGB_W-1:0] cur_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			for (int c = 0; c < 3; c++) begin
				pc_s2[c] <= (CH+16)'(cur_rd[c*CH +: CH]) * (CH+16)'(left_s1);
				pn_s2[c] <= (CH+16)'(nxt_rd[c*CH +: CH]) * (CH+16)'(into_s1);
			end
			seg_s2  <= seg_s1;
			fade_s2 <= fade_s1;
			cur_s2  <= cur_rd;
		end
	end

	// stage 3: blend numerators, at most 255 times the transition length when fading
	logic [BW-1:0]  num_s3 [3];
	logic [S3W-1:0] side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			for (int c = 0; c < 3; c++) begin
				num_s3[c] <= BW'(pc_s2[c] + pn_s2[c]);
			end
			side_s3 <= {seg_s2, fade_s2, cur_s2};
		end
	end

	// divide by the transition length, all three channels together
	logic [CH-1:0]  quo3 [3];
	logic [BW-1:0]  rem3 [3];
	logic [S3W-1:0] side_o;
	logic [csc_pkg::RGB_W-1:0] cur_o;
	logic [csc_pkg::RGB_W-1:0] rgb_o;
	logic           fade_o;

	csc_divpipe #(.NW(BW), .QW(CH), .LANES(3), .SW(S3W)) u_blend (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s3), .in_ready(div3_ready),
		.in_num(num_s3), .in_den(BW'(transition_q)), .in_side(side_s3),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_quo(quo3), .out_rem(rem3), .out_side(side_o)
	);

	assign cur_o  = side_o[csc_pkg::RGB_W-1:0];
	assign fade_o = side_o[csc_pkg::RGB_W];
	assign rgb_o  = fade_o ? {quo3[2], quo3[1], quo3[0]} : cur_o;

	assign out_red       = rgb_o[3*CH-1:2*CH];
	assign out_green     = rgb_o[2*CH-1:CH];
	assign out_blue      = rgb_o[CH-1:0];
	assign fading        = fade_o;
	assign segment_index = 4'(side_o[S3W-1 -: IW]);

	// a crossfade result needs a nonzero transition
	a_fade_needs_transition: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fading |-> transition_q != '0)
		else $error("fading result with zero transition");

	// the segment lies within the colours in use
	a_segment_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(side_o[S3W-1 -: IW]) < 32'(cnt_eff))
		else $error("segment index beyond colour count");

	// zero period always shows entry 0 without fading
	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && period == '0 |-> segment_index == 4'd0 && !fading)
		else $error("zero period result not entry 0");

	// a stalled table stage keeps its read data
	a_table_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy2 |=> $stable(cur_rd) && $stable(nxt_rd))
		else $error("table read data changed under stall");

endmodule

// ===== design/csc_ram.sv =====
// csc_ram: generic single-write, single-read ram with registered read data
// no dependencies
module csc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/csc_divpipe.sv =====
// csc_divpipe: elastic restoring divider, one quotient bit per stage
// quotient must fit QW bits; lanes share one divisor; no package use
module csc_divpipe #(
	parameter int NW    = 24,
	parameter int QW    = 8,
	parameter int LANES = 1,
	parameter int SW    = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [NW-1:0] in_num [LANES],
	input  logic [NW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [QW-1:0] out_quo [LANES],
	output logic [NW-1:0] out_rem [LANES],
	output logic [SW-1:0] out_side
);

	logic [QW-1:0] v_q;
	logic [NW-1:0] rem_q  [QW][LANES];
	logic [QW-1:0] quo_q  [QW][LANES];
	logic [NW-1:0] den_q  [QW];
	logic [SW-1:0] side_q [QW];
	logic [QW:0]   rdy;

	assign rdy[QW] = out_ready;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic          vin;
		logic [NW-1:0] rin [LANES];
		logic [QW-1:0] qin [LANES];
		logic [NW-1:0] din;
		logic [SW-1:0] sin;

		if (k == 0) begin : g_first
			assign vin = in_valid;
			assign din = in_den;
			assign sin = in_side;
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign rin[l] = in_num[l];
				assign qin[l] = '0;
			end
		end else begin : g_next
			assign vin = v_q[k-1];
			assign din = den_q[k-1];
			assign sin = side_q[k-1];
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign rin[l] = rem_q[k-1][l];
				assign qin[l] = quo_q[k-1][l];
			end
		end

		assign rdy[k] = !v_q[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_q[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vin) begin
				den_q[k]  <= din;
				side_q[k] <= sin;
				for (int l = 0; l < LANES; l++) begin
					if ((rin[l] >> B) >= din) begin
						rem_q[k][l] <= rin[l] - (din << B);
						quo_q[k][l] <= qin[l] | (QW'(1) << B);
					end else begin
						rem_q[k][l] <= rin[l];
						quo_q[k][l] <= qin[l];
					end
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_q[QW-1];
	assign out_side  = side_q[QW-1];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign out_quo[l] = quo_q[QW-1][l];
		assign out_rem[l] = rem_q[QW-1][l];
	end

endmodule

// ===== tb/color_sequence_crossfade_tb.sv =====
// color_sequence_crossfade_tb: self-checking bench for the colour sequence crossfade block
// drives table writes and tick transfers, predicts each colour result and compares in order
// depends on csc_pkg and the color_sequence_crossfade rtl
`timescale 1ns / 100ps

module color_sequence_crossfade_tb;

	// pipeline is TICK_BITS + clog2(MAX_COLORS) + 11 deep; leave a margin on top
	localparam int PIPE_DEPTH = 32 + 4 + 11;
	localparam int SETTLE     = PIPE_DEPTH + 20;

	typedef struct {
		logic        op;
		logic [31:0] ticks;
		logic [3:0]  idx;
		logic [7:0]  r, g, b;
	} stim_t;

	typedef struct {
		logic [7:0] r, g, b;
		logic [3:0] seg;
		logic       fade;
	} colour_t;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid, in_ready;
	logic        opcode;
	logic [31:0] tick_count;
	logic [3:0]  entry_index;
	logic [7:0]  entry_red, entry_green, entry_blue;
	logic        out_valid, out_ready;
	logic [7:0]  out_red, out_green, out_blue;
	logic [3:0]  segment_index;
	logic        fading;

	color_sequence_crossfade u_dut (.*);

	// local copy of the block's state
	logic [csc_pkg::RGB_W-1:0] palette [16];
	logic [15:0]      hold_len, fade_len;
	logic [4:0]       n_colours;

	stim_t   pend_q [$];
	colour_t colour_q [$];
	stim_t   cur;
	bit      in_taken, quiet;
	int      in_gap, out_gap, err_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected colour for one tick
	function automatic colour_t predict_colour(input logic [31:0] ticks);
		colour_t         c;
		longint unsigned span, pos, seg_pos, into, left, v;
		int unsigned     cnt, nxt;
		logic [csc_pkg::RGB_W-1:0] a, z;
		cnt = n_colours;
		if (cnt == 0) cnt = 1;
		if (cnt > 16) cnt = 16;
		span = longint'(hold_len) + longint'(fade_len);
		c.seg = '0;
		c.fade = 1'b0;
		a = palette[0];
		{c.r, c.g, c.b} = a;
		if (span != 0) begin
			pos = longint'(ticks) % (span * cnt);
			c.seg = 4'(pos / span);
			seg_pos = pos % span;
			a = palette[c.seg];
			{c.r, c.g, c.b} = a;
			// fade begins one tick after the sustain part ends
			if (fade_len != 0 && seg_pos > hold_len) begin
				nxt = c.seg + 1;
				if (nxt >= cnt) nxt = 0;
				z = palette[nxt];
				into = seg_pos - hold_len;
				left = fade_len - into;
				v = (longint'(a[23:16]) * left + longint'(z[23:16]) * into) / fade_len;
				c.r = v[7:0];
				v = (longint'(a[15:8]) * left + longint'(z[15:8]) * into) / fade_len;
				c.g = v[7:0];
				v = (longint'(a[7:0]) * left + longint'(z[7:0]) * into) / fade_len;
				c.b = v[7:0];
				c.fade = 1'b1;
			end
		end
		return c;
	endfunction

	// input driver: acceptance seen at the rising edge, new item at the falling edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (cur.op == csc_pkg::OP_WRITE)
				palette[cur.idx] = {cur.r, cur.g, cur.b};
			else
				colour_q.push_back(predict_colour(cur.ticks));
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				in_gap = $urandom_range(0, 16);
				in_valid <= 1'b0;
			end else if (pend_q.size() != 0) begin
				cur = pend_q.pop_front();
				in_valid    <= 1'b1;
				opcode      <= cur.op;
				tick_count  <= cur.ticks;
				entry_index <= cur.idx;
				entry_red   <= cur.r;
				entry_green <= cur.g;
				entry_blue  <= cur.b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor with random back-pressure bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				out_gap = $urandom_range(0, 16);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		colour_t e;
		if (arst_n && out_valid && out_ready) begin
			if (colour_q.size() == 0) begin
				$error("result transfer with nothing expected");
				err_cnt++;
			end else begin
				e = colour_q.pop_front();
				if (out_red !== e.r) begin
					$error("out_red exp %0d got %0d", e.r, out_red);
					err_cnt++;
				end
				if (out_green !== e.g) begin
					$error("out_green exp %0d got %0d", e.g, out_green);
					err_cnt++;
				end
				if (out_blue !== e.b) begin
					$error("out_blue exp %0d got %0d", e.b, out_blue);
					err_cnt++;
				end
				if (segment_index !== e.seg) begin
					$error("segment_index exp %0d got %0d", e.seg, segment_index);
					err_cnt++;
				end
				if (fading !== e.fade) begin
					$error("fading exp %0d got %0d", e.fade, fading);
					err_cnt++;
				end
			end
		end
	end

	task automatic add_entry(input logic [3:0] idx, input logic [csc_pkg::RGB_W-1:0] rgb);
		stim_t s;
		s.op = csc_pkg::OP_WRITE;
		s.ticks = $urandom;
		s.idx = idx;
		{s.r, s.g, s.b} = rgb;
		pend_q.push_back(s);
	endtask

	task automatic add_tick(input logic [31:0] ticks);
		stim_t s;
		s.op = csc_pkg::OP_TICK;
		s.ticks = ticks;
		s.idx = $urandom;
		{s.r, s.g, s.b} = 24'($urandom);
		pend_q.push_back(s);
	endtask

	// config only while idle: queue empty, results in, writes flushed from the pipe
	task automatic drain();
		forever begin
			wait (pend_q.size() == 0 && !in_valid && colour_q.size() == 0);
			@(negedge clk);
			if (pend_q.size() == 0 && !in_valid && colour_q.size() == 0) break;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		case (idx)
			csc_pkg::CFG_SUSTAIN:    hold_len = val;
			csc_pkg::CFG_TRANSITION: fade_len = val;
			csc_pkg::CFG_COUNT:      n_colours = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_seq(input logic [15:0] h, input logic [15:0] f, input logic [15:0] n);
		write_reg(csc_pkg::CFG_SUSTAIN, h);
		write_reg(csc_pkg::CFG_TRANSITION, f);
		write_reg(csc_pkg::CFG_COUNT, n);
	endtask

	// ticks near the start of a fade, some fully random, some table rewrites
	task automatic random_phase(input int n);
		longint unsigned span;
		int unsigned     cnt;
		logic [31:0]     t;
		span = longint'(hold_len) + longint'(fade_len);
		cnt = (n_colours == 0) ? 1 : (n_colours > 16 ? 16 : n_colours);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: add_entry(4'($urandom), 24'($urandom));
				2, 3: add_tick($urandom);
				default: begin
					t = 32'($urandom_range(0, 5000) * span * cnt
						+ $urandom_range(0, cnt - 1) * span + hold_len);
					t = t + 32'($urandom_range(0, 6)) - 32'd3;
					if ($urandom_range(0, 2) == 0)
						t = 32'($urandom_range(0, 32'hffff) * span * cnt
							+ longint'($urandom) % (span * cnt + 1));
					add_tick(t);
				end
			endcase
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = csc_pkg::CFG_SUSTAIN;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = csc_pkg::OP_TICK;
		tick_count = '0;
		entry_index = '0;
		entry_red = '0;
		entry_green = '0;
		entry_blue = '0;
		out_ready = 1'b0;
		hold_len = '0;
		fade_len = '0;
		n_colours = 5'd1;
		err_cnt = 0;
		quiet = 1'b0;
		in_gap = 0;
		out_gap = 0;
		in_taken = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill every slot first so no unwritten entry is ever read
		add_entry(4'd0, 24'h000000);
		add_entry(4'd15, 24'hffffff);
		for (int i = 1; i < 15; i++)
			add_entry(4'(i), 24'($urandom));
		drain();

		// directed: short period across all sixteen colours
		set_seq(16'd3, 16'd4, 16'd16);
		add_tick(32'd0);
		add_tick(32'd3);              // last sustain tick, not yet fading
		add_tick(32'd4);
		add_tick(32'd6);
		add_tick(32'd7);
		add_tick(32'd111);            // final fade back to entry 0
		add_tick(32'hffffffff);
		add_tick(32'h80000000);
		add_entry(4'd1, 24'hff00ff);
		add_tick(32'd10);
		drain();

		// zero period always gives entry 0; index 3 is not a register
		set_seq(16'd0, 16'd0, 16'd5);
		write_reg(2'd3, 16'hffff);
		add_tick(32'd12345);
		add_tick(32'hffffffff);
		drain();

		set_seq(16'hffff, 16'hffff, 16'd16);
		add_tick(32'd65535);
		add_tick(32'd65536);
		add_tick(32'd131069);
		add_tick(32'hffffffff);
		drain();

		// count zero behaves as one, above sixteen as sixteen
		set_seq(16'd0, 16'd1, 16'd0);
		add_tick(32'd1);
		add_tick(32'd2);
		drain();
		set_seq(16'd2, 16'd0, 16'd31);
		add_tick(32'd47);
		add_tick(32'd48);
		drain();

		random_phase(120);
		set_seq(16'hffff, 16'd0, 16'd16);
		random_phase(110);
		set_seq(16'd0, 16'hffff, 16'd1);
		random_phase(110);
		set_seq(16'd0, 16'd0, 16'd16);
		random_phase(60);
		set_seq(16'($urandom_range(0, 20)), 16'($urandom_range(1, 20)), 16'($urandom_range(2, 16)));
		random_phase(130);
		set_seq(16'($urandom), 16'($urandom), 16'd31);
		random_phase(110);
		set_seq(16'd1, 16'd255, 16'd0);
		random_phase(110);
		set_seq(16'($urandom_range(0, 9)), 16'($urandom_range(1, 300)), 16'($urandom_range(1, 16)));
		random_phase(110);

		// final stretch with no idling on either side
		quiet = 1'b1;
		set_seq(16'd5, 16'd7, 16'd9);
		random_phase(120);

		if (err_cnt == 0 && colour_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== color_sequence_crossfade.f =====
design/csc_pkg.sv
design/csc_ram.sv
design/csc_divpipe.sv
design/color_sequence_crossfade.sv
tb/color_sequence_crossfade_tb.sv
